// ===== sv/evpc_pkg.sv =====
`default_nettype none

package evpc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CHAN_W    = FRAC_BITS + 1;
	localparam int PROD_W    = 2 * CHAN_W;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CHAN_W-1:0] ONE  = CHAN_W'(1) << FRAC_BITS;
	localparam logic [CHAN_W-1:0] HALF = CHAN_W'(1) << (FRAC_BITS - 1);

	// Palette constants, rounded to the nearest step of the fraction.
	localparam logic [CHAN_W-1:0] C_0P1  = CHAN_W'((1 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [CHAN_W-1:0] C_0P3  = CHAN_W'((3 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [CHAN_W-1:0] C_0P5  = CHAN_W'((5 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [CHAN_W-1:0] C_0P55 = CHAN_W'((55 * (1 << FRAC_BITS) + 50) / 100);
	localparam logic [CHAN_W-1:0] C_0P6  = CHAN_W'((6 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [CHAN_W-1:0] C_0P7  = CHAN_W'((7 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [CHAN_W-1:0] C_0P9  = CHAN_W'((9 * (1 << FRAC_BITS) + 5) / 10);

	// Odd-power coefficients of the quarter-wave sine polynomial, Q30.
	localparam logic [30:0] CA1 = 31'd1686629713;
	localparam logic [29:0] CA3 = 30'd693598673;
	localparam logic [26:0] CA5 = 27'd85569306;
	localparam logic [22:0] CA7 = 23'd5026998;

	localparam logic REG_PALETTE_MODE = 1'b0;

	typedef enum logic [2:0] {
		PAL_SUNSET   = 3'd0,
		PAL_RAINBOW  = 3'd1,
		PAL_LEAF     = 3'd2,
		PAL_CRYSTAL  = 3'd3,
		PAL_TWILIGHT = 3'd4
	} palette_t;

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} hue_sector_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} sine_en_t;

	typedef struct packed {
		logic s8;
		logic s9;
	} hsv_en_t;

	typedef struct packed {
		palette_t             mode;
		logic                 escaped;
		logic [FRAC_BITS-1:0] frac;
	} item_tag_t;

	typedef struct packed {
		item_tag_t            tag;
		hue_sector_t          sector;
		logic [FRAC_BITS-1:0] hue_frac;
		logic [CHAN_W-1:0]    sat;
		logic [CHAN_W-1:0]    val;
	} hsv_in_t;

	// Rounded fixed-point product of two Q1.16 values.
	function automatic logic [CHAN_W-1:0] fx_mul(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(a) * PROD_W'(b) + PROD_W'(HALF);
		return prod[FRAC_BITS +: CHAN_W];
	endfunction

endpackage

`default_nettype wire

// ===== sv/evpc_sine.sv =====
`default_nettype none

module evpc_sine
	import evpc_pkg::*;
#(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                     clk,
	input  sine_en_t                 en,
	input  logic [SINE_TABLE_BITS:0] index,
	output logic [CHAN_W-1:0]        mag
);

	localparam int IW        = SINE_TABLE_BITS;
	localparam int SQ_SHIFT  = 30 - 2 * IW;
	localparam int RND_SHIFT = 30 - FRAC_BITS;
	localparam int R_W       = 32 - RND_SHIFT;
	localparam logic [IW:0] QTR = (IW + 1)'(1) << IW;

	logic [2*IW-1:0] sq;
	logic [52:0]     p3;
	logic [56:0]     p4;
	logic [59:0]     p5;
	logic [IW+30:0]  p6;
	logic [31:0]     rnd;
	logic [R_W-1:0]  r6;

	logic [IW-1:0] i_lo_s2, i_lo_s3, i_lo_s4, i_lo_s5;
	logic          full_s2, full_s3, full_s4, full_s5;
	logic [29:0]   x2_s2, x2_s3, x2_s4;
	logic [26:0]   t1_s3;
	logic [29:0]   t2_s4;
	logic [30:0]   t3_s5;
	logic [CHAN_W-1:0] mag_s6;

	// x^2 in Q30 is the squared index shifted up, with no bits lost.
	assign sq  = (2 * IW)'(index[IW-1:0]) * (2 * IW)'(index[IW-1:0]);
	assign p3  = 53'(x2_s2) * 53'(CA7);
	assign p4  = 57'(x2_s3) * 57'(t1_s3);
	assign p5  = 60'(x2_s4) * 60'(t2_s4);
	assign p6  = (IW + 31)'(i_lo_s5) * (IW + 31)'(t3_s5);
	assign rnd = 32'(p6[IW +: 31]) + (32'(1) << (RND_SHIFT - 1));
	assign r6  = rnd[RND_SHIFT +: R_W];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			i_lo_s2 <= index[IW-1:0];
			full_s2 <= (index == QTR);
			x2_s2   <= {sq, {SQ_SHIFT{1'b0}}};
		end
		if (en.s3) begin
			i_lo_s3 <= i_lo_s2;
			full_s3 <= full_s2;
			x2_s3   <= x2_s2;
			t1_s3   <= CA5 - 27'(p3[52:30]);
		end
		if (en.s4) begin
			i_lo_s4 <= i_lo_s3;
			full_s4 <= full_s3;
			x2_s4   <= x2_s3;
			t2_s4   <= CA3 - 30'(p4[56:30]);
		end
		if (en.s5) begin
			i_lo_s5 <= i_lo_s4;
			full_s5 <= full_s4;
			t3_s5   <= CA1 - 31'(p5[59:30]);
		end
		if (en.s6) begin
			if (full_s5 || r6 > R_W'(ONE)) begin
				mag_s6 <= ONE;
			end else begin
				mag_s6 <= r6[CHAN_W-1:0];
			end
		end
	end

	assign mag = mag_s6;

endmodule

`default_nettype wire

// ===== sv/evpc_hsv.sv =====
`default_nettype none

module evpc_hsv
	import evpc_pkg::*;
(
	input  logic              clk,
	input  hsv_en_t           en,
	input  hsv_in_t           pix,
	output logic [CHAN_W-1:0] red,
	output logic [CHAN_W-1:0] green,
	output logic [CHAN_W-1:0] blue
);

	localparam int TW_DROP = FRAC_BITS - 8;
	localparam logic [FRAC_BITS-1:0] TW_RED_MULT   = FRAC_BITS'(7);
	localparam logic [FRAC_BITS-1:0] TW_GREEN_MULT = FRAC_BITS'(5);
	localparam logic [FRAC_BITS-1:0] TW_BLUE_MULT  = FRAC_BITS'(3);

	// Fractional part of frac*k, kept to its top eight bits.
	function automatic logic [CHAN_W-1:0] twilight(input logic [FRAC_BITS-1:0] frac,
		input logic [FRAC_BITS-1:0] k);
		logic [FRAC_BITS-1:0] prod;
		prod = frac * k;
		return CHAN_W'({prod[FRAC_BITS-1:TW_DROP], {TW_DROP{1'b0}}});
	endfunction

	logic [CHAN_W-1:0] f_ext;
	logic [CHAN_W-1:0] q9, t9;
	logic [CHAN_W-1:0] r_d, g_d, b_d;

	logic [CHAN_W-1:0] sf_s8, sf1_s8, p_s8, val_s8;
	logic              gray_s8;
	hue_sector_t       sector_s8;
	item_tag_t         tag_s8;
	logic [CHAN_W-1:0] red_s9, green_s9, blue_s9;

	assign f_ext = {1'b0, pix.hue_frac};

	always_ff @(posedge clk) begin
		if (en.s8) begin
			sf_s8     <= fx_mul(pix.sat, f_ext);
			sf1_s8    <= fx_mul(pix.sat, ONE - f_ext);
			p_s8      <= fx_mul(pix.val, ONE - pix.sat);
			val_s8    <= pix.val;
			gray_s8   <= (pix.sat == '0);
			sector_s8 <= pix.sector;
			tag_s8    <= pix.tag;
		end
	end

	assign q9 = fx_mul(val_s8, ONE - sf_s8);
	assign t9 = fx_mul(val_s8, ONE - sf1_s8);

	always_comb begin
		r_d = '0;
		g_d = '0;
		b_d = '0;
		if (!tag_s8.escaped) begin
			case (tag_s8.mode)
				PAL_SUNSET, PAL_RAINBOW, PAL_LEAF, PAL_CRYSTAL: begin
					r_d = val_s8;
					g_d = val_s8;
					b_d = val_s8;
					if (!gray_s8) begin
						case (sector_s8)
							SEC_RY: begin
								g_d = t9;
								b_d = p_s8;
							end
							SEC_YG: begin
								r_d = q9;
								b_d = p_s8;
							end
							SEC_GC: begin
								r_d = p_s8;
								b_d = t9;
							end
							SEC_CB: begin
								r_d = p_s8;
								g_d = q9;
							end
							SEC_BM: begin
								r_d = t9;
								g_d = p_s8;
							end
							default: begin
								g_d = p_s8;
								b_d = q9;
							end
						endcase
					end
				end
				PAL_TWILIGHT: begin
					r_d = twilight(tag_s8.frac, TW_RED_MULT);
					g_d = twilight(tag_s8.frac, TW_GREEN_MULT);
					b_d = twilight(tag_s8.frac, TW_BLUE_MULT);
				end
				default: begin
					r_d = '0;
					g_d = '0;
					b_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en.s9) begin
			red_s9   <= r_d;
			green_s9 <= g_d;
			blue_s9  <= b_d;
		end
	end

	assign red   = red_s9;
	assign green = green_s9;
	assign blue  = blue_s9;

endmodule

`default_nettype wire

// ===== sv/escape_value_palette_colorizer.sv =====
// Escape-value palette colorizer: turns a normalized escape value (Q1.16) into an
// RGBA pixel with Q1.16 channels under the palette held in the palette_mode register.
// The input channel (in_valid, in_stall, escape_value) takes one transaction per
// clock while in_stall is low; the output channel (out_valid, out_stall, red, green,
// blue, alpha) returns one pixel per input transaction, in order. Alpha is always full
// opacity. The pipeline has nine stages, and throughput is one pixel per clock while
// out_stall is low. The phase fold takes the first stage, the sine polynomial takes
// five, one multiply each, and the wave scaling and the two levels of HSV products take
// the last three.
// Each stage holds its own valid bit, so when out_stall is high the pipeline keeps taking
// transactions until every stage is full, and only then raises in_stall. Nothing is lost
// or repeated across a stall.
// The configuration port is APB style with pready tied high. palette_mode lies at byte
// address 0; writes to any other register index are ignored and read back as zero.
// Mode codes 5 to 7 give opaque black, as does an escape value of 1.0 or more.
// Reset (arst_n low) empties the pipeline and sets palette_mode to sunset. It should only
// be written while no transaction is in flight.
`default_nettype none

module escape_value_palette_colorizer
	import evpc_pkg::*;
#(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAN_W-1:0]    escape_value,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHAN_W-1:0]    red,
	output logic [CHAN_W-1:0]    green,
	output logic [CHAN_W-1:0]    blue,
	output logic [CHAN_W-1:0]    alpha,

	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	localparam int NSTAGES    = 9;
	localparam int PHASE_BITS = SINE_TABLE_BITS + 2;
	localparam int PH_LSB     = FRAC_BITS - PHASE_BITS;
	localparam logic [SINE_TABLE_BITS:0] QTR_IDX =
		(SINE_TABLE_BITS + 1)'(1) << SINE_TABLE_BITS;
	localparam logic [PHASE_BITS-1:0] QTR_PH = PHASE_BITS'(1) << SINE_TABLE_BITS;

	localparam logic [FRAC_BITS-1:0] SAT_MULT     = FRAC_BITS'(6);
	localparam logic [FRAC_BITS-1:0] RAINBOW_MULT = FRAC_BITS'(12);
	localparam logic [FRAC_BITS-1:0] LEAF_MULT    = FRAC_BITS'(8);
	localparam logic [FRAC_BITS-1:0] HUE_MULT     = FRAC_BITS'(6);
	localparam int HS_W = FRAC_BITS + 3;

	typedef struct packed {
		item_tag_t tag;
		logic      neg_a;
		logic      neg_b;
	} lane_tag_t;

	// Folds a phase into a quarter-wave index, mirroring the odd quadrants.
	function automatic logic [SINE_TABLE_BITS:0] fold_index(input logic [PHASE_BITS-1:0] ph);
		logic [SINE_TABLE_BITS:0] i;
		i = {1'b0, ph[SINE_TABLE_BITS-1:0]};
		return ph[SINE_TABLE_BITS] ? QTR_IDX - i : i;
	endfunction

	// base plus or minus amp*|wave|, held within zero and full scale.
	function automatic logic [CHAN_W-1:0] wave_mix(input logic [CHAN_W-1:0] base,
		input logic [CHAN_W-1:0] amp, input logic [CHAN_W-1:0] mag, input logic neg);
		logic [CHAN_W-1:0] prod;
		logic [CHAN_W:0]   sum;
		prod = fx_mul(amp, mag);
		sum  = {1'b0, base} + {1'b0, prod};
		if (neg) begin
			return (prod >= base) ? '0 : base - prod;
		end
		return (sum > {1'b0, ONE}) ? ONE : sum[CHAN_W-1:0];
	endfunction

	// ---------------------------------------------------------------- config
	palette_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PAL_SUNSET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PALETTE_MODE) begin
			mode_q <= palette_t'(pwdata[2:0]);
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PALETTE_MODE) ? DATA_W'(mode_q) : '0;

	// ---------------------------------------------------------------- flow control
	// A stage may load whenever it is empty or the stage after it moves on.
	logic [NSTAGES:1] vld_q;
	logic [NSTAGES:1] vld_in;
	logic [NSTAGES:1] rdy;

	assign vld_in = {vld_q[NSTAGES-1:1], in_valid};
	assign rdy[NSTAGES] = !vld_q[NSTAGES] || !out_stall;

	for (genvar k = 1; k < NSTAGES; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[NSTAGES];

	// ---------------------------------------------------------------- stage 1
	// Lane A carries the saturation sine, lane B the value cosine. Only the low
	// bits of k*p matter because the phase wraps once per turn.
	logic [FRAC_BITS-1:0]  frac_in;
	logic [FRAC_BITS-1:0]  prod_a, prod_b;
	logic [PHASE_BITS-1:0] ph_a, ph_b;
	item_tag_t             tag_in;

	assign frac_in = escape_value[FRAC_BITS-1:0];
	assign prod_a  = frac_in * SAT_MULT;
	assign prod_b  = frac_in * ((mode_q == PAL_RAINBOW) ? RAINBOW_MULT : LEAF_MULT);
	assign ph_a    = prod_a[FRAC_BITS-1:PH_LSB];
	assign ph_b    = prod_b[FRAC_BITS-1:PH_LSB] + QTR_PH;
	assign tag_in  = '{mode: mode_q, escaped: escape_value[FRAC_BITS], frac: frac_in};

	logic [SINE_TABLE_BITS:0] idx_a_s1, idx_b_s1;
	lane_tag_t lt_s1, lt_s2, lt_s3, lt_s4, lt_s5, lt_s6;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			idx_a_s1 <= fold_index(ph_a);
			idx_b_s1 <= fold_index(ph_b);
			lt_s1    <= '{tag: tag_in, neg_a: ph_a[PHASE_BITS-1], neg_b: ph_b[PHASE_BITS-1]};
		end
		if (rdy[2]) lt_s2 <= lt_s1;
		if (rdy[3]) lt_s3 <= lt_s2;
		if (rdy[4]) lt_s4 <= lt_s3;
		if (rdy[5]) lt_s5 <= lt_s4;
		if (rdy[6]) lt_s6 <= lt_s5;
	end

	// ---------------------------------------------------------------- stages 2..6
	sine_en_t          sine_en;
	logic [CHAN_W-1:0] mag_a_s6, mag_b_s6;

	assign sine_en = '{s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5], s6: rdy[6]};

	evpc_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_sine_a (
		.clk  (clk),
		.en   (sine_en),
		.index(idx_a_s1),
		.mag  (mag_a_s6)
	);

	evpc_sine #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_sine_b (
		.clk  (clk),
		.en   (sine_en),
		.index(idx_b_s1),
		.mag  (mag_b_s6)
	);

	// ---------------------------------------------------------------- stage 7
	// Pick hue, saturation and value for the palette and split the hue into
	// its sixth of the circle and the position inside it.
	logic              rainbow6;
	logic [CHAN_W-1:0] sat_wave, val_wave;
	logic [FRAC_BITS-1:0] hue;
	logic [CHAN_W-1:0] sat_d, val_d;
	logic [HS_W-1:0]   hs;
	hsv_in_t           hsv_in_s7;

	assign rainbow6 = (lt_s6.tag.mode == PAL_RAINBOW);
	assign sat_wave = wave_mix(C_0P3, C_0P3, mag_a_s6, lt_s6.neg_a);
	assign val_wave = wave_mix(rainbow6 ? C_0P9 : C_0P7, rainbow6 ? C_0P1 : C_0P3,
		mag_b_s6, lt_s6.neg_b);

	always_comb begin
		case (lt_s6.tag.mode)
			PAL_SUNSET: begin
				hue   = lt_s6.tag.frac;
				sat_d = C_0P6;
				val_d = ONE;
			end
			PAL_RAINBOW: begin
				hue   = lt_s6.tag.frac * HUE_MULT;
				sat_d = C_0P5;
				val_d = val_wave;
			end
			PAL_LEAF: begin
				hue   = C_0P3[FRAC_BITS-1:0];
				sat_d = sat_wave;
				val_d = val_wave;
			end
			PAL_CRYSTAL: begin
				hue   = C_0P55[FRAC_BITS-1:0];
				sat_d = sat_wave;
				val_d = val_wave;
			end
			default: begin
				hue   = '0;
				sat_d = '0;
				val_d = '0;
			end
		endcase
	end

	assign hs = HS_W'(hue) * HS_W'(HUE_MULT);

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			hsv_in_s7 <= '{
				tag:      lt_s6.tag,
				sector:   hue_sector_t'(hs[HS_W-1:FRAC_BITS]),
				hue_frac: hs[FRAC_BITS-1:0],
				sat:      sat_d,
				val:      val_d
			};
		end
	end

	// ---------------------------------------------------------------- stages 8..9
	hsv_en_t hsv_en;

	assign hsv_en = '{s8: rdy[8], s9: rdy[9]};

	evpc_hsv u_hsv (
		.clk  (clk),
		.en   (hsv_en),
		.pix  (hsv_in_s7),
		.red  (red),
		.green(green),
		.blue (blue)
	);

	assign alpha = ONE;

	// ---------------------------------------------------------------- checks
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && out_stall) |-> in_stall)
		else $error("pipeline full under output stall but input not stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted transaction did not enter the first stage");

	a_hsv_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] |-> (hsv_in_s7.sat <= ONE && hsv_in_s7.val <= ONE))
		else $error("saturation or value above full scale");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= ONE && green <= ONE && blue <= ONE))
		else $error("output channel above full scale");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import evpc_pkg::*;

	// The predictor works in 64-bit unsigned arithmetic so that no intermediate
	// product of the sine polynomial can overflow.
	typedef logic [63:0] u64_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	localparam int   SINE_BITS  = 10;
	localparam int   PHASE_BITS = SINE_BITS + 2;
	localparam int   HOLD_CYCLES = 80;

	localparam u64_t ONE64      = 64'd1 << FRAC_BITS;
	localparam u64_t FRAC_MASK  = ONE64 - 64'd1;
	localparam u64_t QTR        = 64'd1 << SINE_BITS;
	localparam u64_t PHASE_MASK = (QTR << 2) - 64'd1;
	localparam u64_t TWILIGHT_MASK = FRAC_MASK & ~((64'd1 << (FRAC_BITS - 8)) - 64'd1);

	// Palette constants, rounded to the nearest step of the fraction.
	localparam u64_t SAT_SUNSET  = (64'd6 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t VAL_RAINBOW = (64'd9 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t AMP_RAINBOW = (64'd1 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t SAT_RAINBOW = (64'd5 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t SAT_FOLIAGE = (64'd3 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t AMP_FOLIAGE = (64'd3 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t VAL_FOLIAGE = (64'd7 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t HUE_LEAF    = (64'd3 * ONE64 + 64'd5) / 64'd10;
	localparam u64_t HUE_CRYSTAL = (64'd55 * ONE64 + 64'd50) / 64'd100;

	// Odd-power coefficients of the quarter-wave sine polynomial, Q30.
	localparam u64_t SIN_K1 = 64'd1686629713;
	localparam u64_t SIN_K3 = 64'd693598673;
	localparam u64_t SIN_K5 = 64'd85569306;
	localparam u64_t SIN_K7 = 64'd5026998;

	// Mode codes past the last palette; the block must answer them with black.
	localparam logic [2:0] PAL_UNUSED_LO = 3'd5;
	localparam logic [2:0] PAL_UNUSED_HI = 3'd7;

	// Register map: palette_mode is register 0 at byte address 0. Address 4 is
	// register 1, which does not exist and must ignore writes.
	localparam logic [ADDR_W-1:0] PALETTE_ADDR = ADDR_W'(REG_PALETTE_MODE) << 2;
	localparam logic [ADDR_W-1:0] UNUSED_ADDR  = ADDR_W'(4);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CHAN_W-1:0] escape_value = '0;
	logic              out_valid;
	logic              out_stall = 1'b1;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Escape values waiting to be offered, and the pixels predicted for the
	// transactions the block has already taken, oldest first.
	logic [CHAN_W-1:0] pending_values[$];
	pixel_t            expected_pixels[$];
	pixel_t            due_pixel;

	// Our own copy of the palette register, updated only while the block is idle.
	logic [2:0]        palette_shadow = PAL_SUNSET;

	int                mismatch_count = 0;
	int                offered_count = 0;
	int                accepted_count = 0;
	int                send_idle_pct = 32;
	int                recv_idle_pct = 32;
	int                hold_requests = 0;
	int                hold_served = 0;
	int                hold_left = 0;

	escape_value_palette_colorizer #(
		.SINE_TABLE_BITS(SINE_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.escape_value (escape_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// ------------------------------------------------------------------
	// Pixel predictor.
	// ------------------------------------------------------------------

	// Q16 product rounded to nearest.
	function automatic u64_t q16_mul(input u64_t a, input u64_t b);
		return (a * b + (ONE64 >> 1)) >> FRAC_BITS;
	endfunction

	// One entry of the quarter-wave sine table: the polynomial evaluated in Q30,
	// rounded to Q16 and clamped to one. Index QTR and beyond is exactly one.
	function automatic u64_t sine_quarter(input u64_t idx);
		u64_t x, x2, acc, s, r;
		if (idx >= QTR)
			return ONE64;
		x   = idx << (30 - SINE_BITS);
		x2  = (x * x) >> 30;
		acc = SIN_K5 - ((x2 * SIN_K7) >> 30);
		acc = SIN_K3 - ((x2 * acc) >> 30);
		acc = SIN_K1 - ((x2 * acc) >> 30);
		s   = (x * acc) >> 30;
		r   = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		return (r > ONE64) ? ONE64 : r;
	endfunction

	// Full-circle sine built from the quarter table: the second and fourth
	// quadrants mirror the index, the lower half of the circle is negative.
	function automatic logic sine_full(input u64_t ph, output u64_t mag);
		u64_t quad, idx;
		ph   = ph & PHASE_MASK;
		quad = ph >> SINE_BITS;
		idx  = ph & (QTR - 64'd1);
		mag  = quad[0] ? sine_quarter(QTR - idx) : sine_quarter(idx);
		return quad >= 64'd2;
	endfunction

	// Phase in table steps of mult turns times the escape value, truncated.
	function automatic u64_t wave_phase(input u64_t mult, input u64_t p);
		return (mult * p) >> (FRAC_BITS - PHASE_BITS);
	endfunction

	// base + amp * sin (or cos), clamped to the range zero to one.
	function automatic u64_t wave_level(input u64_t base, input u64_t amp, input u64_t ph,
		input logic use_cos);
		u64_t mag, prod;
		logic neg;
		neg  = sine_full(use_cos ? ph + QTR : ph, mag);
		prod = q16_mul(amp, mag);
		if (neg)
			return (prod >= base) ? 64'd0 : base - prod;
		return (base + prod > ONE64) ? ONE64 : base + prod;
	endfunction

	// HSV to RGB by sixths of the hue circle. Zero saturation is plain gray.
	function automatic void hsv_sextant(input u64_t h, input u64_t s, input u64_t v,
		output u64_t r, output u64_t g, output u64_t b);
		u64_t hs, sec, f, pv, qv, tv;
		r = v;
		g = v;
		b = v;
		if (s == 64'd0)
			return;
		hs  = (h & FRAC_MASK) * 64'd6;
		sec = hs >> FRAC_BITS;
		f   = hs & FRAC_MASK;
		pv  = q16_mul(v, ONE64 - s);
		qv  = q16_mul(v, ONE64 - q16_mul(s, f));
		tv  = q16_mul(v, ONE64 - q16_mul(s, ONE64 - f));
		case (hue_sector_t'(sec[2:0]))
			SEC_RY: begin
				g = tv;
				b = pv;
			end
			SEC_YG: begin
				r = qv;
				b = pv;
			end
			SEC_GC: begin
				r = pv;
				b = tv;
			end
			SEC_CB: begin
				r = pv;
				g = qv;
			end
			SEC_BM: begin
				r = tv;
				g = pv;
			end
			default: begin
				g = pv;
				b = qv;
			end
		endcase
	endfunction

	function automatic pixel_t predict_pixel(input logic [2:0] mode,
		input logic [CHAN_W-1:0] ev);
		pixel_t px;
		u64_t   p, s, v, r, g, b;
		p = u64_t'(ev);
		r = 64'd0;
		g = 64'd0;
		b = 64'd0;
		// Escaped points stay black in every palette.
		if (p < ONE64) begin
			case (mode)
				PAL_SUNSET: begin
					hsv_sextant(p, SAT_SUNSET, ONE64, r, g, b);
				end
				PAL_RAINBOW: begin
					v = wave_level(VAL_RAINBOW, AMP_RAINBOW, wave_phase(64'd12, p), 1'b1);
					hsv_sextant((64'd6 * p) & FRAC_MASK, SAT_RAINBOW, v, r, g, b);
				end
				PAL_LEAF, PAL_CRYSTAL: begin
					s = wave_level(SAT_FOLIAGE, AMP_FOLIAGE, wave_phase(64'd6, p), 1'b0);
					v = wave_level(VAL_FOLIAGE, AMP_FOLIAGE, wave_phase(64'd8, p), 1'b1);
					hsv_sextant((mode == PAL_LEAF) ? HUE_LEAF : HUE_CRYSTAL, s, v, r, g, b);
				end
				PAL_TWILIGHT: begin
					r = (p * 64'd7) & TWILIGHT_MASK;
					g = (p * 64'd5) & TWILIGHT_MASK;
					b = (p * 64'd3) & TWILIGHT_MASK;
				end
				default: begin
				end
			endcase
		end
		px.red   = r[CHAN_W-1:0];
		px.green = g[CHAN_W-1:0];
		px.blue  = b[CHAN_W-1:0];
		px.alpha = ONE64[CHAN_W-1:0];
		return px;
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers the queued escape values at falling edges. A new value is
	// put up only once the previous transaction went through, so a stalled
	// payload never changes. Idle cycles are drawn at random.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || accepted_count == offered_count) begin
			if (arst_n && pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				escape_value <= pending_values.pop_front();
				offered_count++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The output side stalls at random, and on request holds off for a long
	// stretch so that the pipeline fills and pushes back on the input.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic check_channel(input string name, input logic [CHAN_W-1:0] want,
		input logic [CHAN_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: at each rising edge a completed output transaction is checked
	// against the oldest prediction, and a completed input transaction gets its
	// pixel predicted under the current palette. The output check comes first so
	// that a stray pixel is never matched against a prediction made this cycle.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel with no transaction waiting: r=%0d g=%0d b=%0d a=%0d",
						red, green, blue, alpha);
					mismatch_count++;
				end else begin
					due_pixel = expected_pixels.pop_front();
					check_channel("red", due_pixel.red, red);
					check_channel("green", due_pixel.green, green);
					check_channel("blue", due_pixel.blue, blue);
					check_channel("alpha", due_pixel.alpha, alpha);
				end
			end
			if (in_valid && !in_stall) begin
				expected_pixels.push_back(predict_pixel(palette_shadow, escape_value));
				accepted_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration port helpers: setup cycle, then access cycle.
	// ------------------------------------------------------------------
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata mismatch at address %0d: expected %0d, actual %0d", addr, want, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Returns once every queued value has been taken and every pixel seen.
	task automatic wait_drained();
		while (pending_values.size() != 0 || accepted_count != offered_count
			|| expected_pixels.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// The palette only changes while nothing is in flight. Unused upper bits of
	// the write data are sometimes set; only the low three bits matter.
	task automatic set_palette(input logic [2:0] mode);
		wait_drained();
		apb_write(PALETTE_ADDR, {($urandom_range(1) != 0) ? 29'($urandom()) : 29'd0, mode});
		palette_shadow = mode;
		check_register(PALETTE_ADDR, DATA_W'(mode));
	endtask

	// Mostly uniform fractions, with a share of escaped values (bit 16 set) and
	// a share of the range ends.
	function automatic logic [CHAN_W-1:0] random_escape();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return CHAN_W'(ONE64) | CHAN_W'($urandom_range(65535));
		if (pick < 12) begin
			case ($urandom_range(3))
				0: return CHAN_W'(0);
				1: return CHAN_W'(1);
				2: return CHAN_W'(FRAC_MASK);
				default: return CHAN_W'(ONE64);
			endcase
		end
		return CHAN_W'($urandom_range(65535));
	endfunction

	// ------------------------------------------------------------------
	// Stimulus sequence.
	// ------------------------------------------------------------------
	initial begin
		int         phase;
		int         batch;
		logic [2:0] next_mode;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset leaves the sunset palette selected.
		check_register(PALETTE_ADDR, DATA_W'(PAL_SUNSET));

		// Sunset: range ends, hue sector boundaries and escaped values,
		// including the one with every input bit set.
		pending_values.push_back(CHAN_W'(0));
		pending_values.push_back(CHAN_W'(1));
		pending_values.push_back(CHAN_W'(10923));
		pending_values.push_back(CHAN_W'(21846));
		pending_values.push_back(CHAN_W'(32768));
		pending_values.push_back(CHAN_W'(43691));
		pending_values.push_back(CHAN_W'(54614));
		pending_values.push_back(CHAN_W'(FRAC_MASK));
		pending_values.push_back(CHAN_W'(ONE64));
		pending_values.push_back(CHAN_W'(17'h1FFFF));

		// Leaf and crystal: at these points the saturation wave bottoms out at
		// zero, so the pixel must come out gray rather than black.
		set_palette(PAL_LEAF);
		pending_values.push_back(CHAN_W'(8192));
		pending_values.push_back(CHAN_W'(19115));
		set_palette(PAL_CRYSTAL);
		pending_values.push_back(CHAN_W'(8192));
		pending_values.push_back(CHAN_W'(30038));

		set_palette(PAL_RAINBOW);
		pending_values.push_back(CHAN_W'(17'h02AAA));
		pending_values.push_back(CHAN_W'(17'h0AAAA));

		set_palette(PAL_TWILIGHT);
		pending_values.push_back(CHAN_W'(FRAC_MASK));
		pending_values.push_back(CHAN_W'(17'h00101));

		// Mode codes with no palette behind them give opaque black.
		set_palette(PAL_UNUSED_LO);
		pending_values.push_back(CHAN_W'(17'h04000));
		set_palette(PAL_UNUSED_HI);
		pending_values.push_back(CHAN_W'(17'h07FFF));

		// A write to a register index that does not exist must change nothing
		// and read back as zero.
		wait_drained();
		apb_write(UNUSED_ADDR, $urandom());
		check_register(UNUSED_ADDR, '0);
		check_register(PALETTE_ADDR, DATA_W'(palette_shadow));
		pending_values.push_back(CHAN_W'(17'h01234));

		// Random phases. The first eight walk through every mode code; the rest
		// pick real palettes. One phase holds off the output for a long stretch
		// while the input keeps offering, and one runs with no idling at all.
		// Each palette change waits for the pipeline to drain first.
		for (phase = 0; phase < 12; phase++) begin
			next_mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(4));
			set_palette(next_mode);
			batch = 100;
			if (phase == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 32;
				hold_requests++;
				batch = 150;
			end else if (phase == 9) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = 32;
				recv_idle_pct = 32;
			end
			repeat (batch) pending_values.push_back(random_escape());
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#200_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== escape_value_palette_colorizer.f =====
sv/evpc_pkg.sv
sv/evpc_sine.sv
sv/evpc_hsv.sv
sv/escape_value_palette_colorizer.sv
test/tb.sv
